FILE: hdl/jsu_pkg.sv
// jsu_pkg: shared types, codes and decode functions for the JSON string unescaper
// used by the front, queue, back and top level; depends on nothing

package jsu_pkg;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // largest number of data bytes one text byte can produce
    localparam int MAX_DATA = 4;

    // parser modes
    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_STR    = 4'd1,
        M_ESC    = 4'd2,
        M_HEX1   = 4'd3,
        M_WANTBS = 4'd4,
        M_WANTU  = 4'd5,
        M_HEX2   = 4'd6,
        M_DRAIN  = 4'd7
    } mode_t;

    // result kinds
    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_DONE = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    // error codes
    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_NO_QUOTE   = 4'd1;
    localparam logic [3:0] E_UNTERM     = 4'd2;
    localparam logic [3:0] E_END_ESC    = 4'd3;
    localparam logic [3:0] E_BAD_ESC    = 4'd4;
    localparam logic [3:0] E_TRUNC_U    = 4'd5;
    localparam logic [3:0] E_BAD_HEX    = 4'd6;
    localparam logic [3:0] E_UNPAIRED   = 4'd7;
    localparam logic [3:0] E_BAD_LOW    = 4'd8;

    // characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // surrogate range tops (upper six bits)
    localparam logic [5:0] SUR_HIGH_TOP = 6'b110110;
    localparam logic [5:0] SUR_LOW_TOP  = 6'b110111;

    // one job: the results caused by one text byte
    typedef struct packed {
        logic [2:0]            n_data;
        logic [MAX_DATA-1:0][7:0] data;
        logic                  tail_en;
        kind_t                 tail_kind;
        logic [3:0]            tail_code;
    } job_t;

    // utf-8 encoder result
    typedef struct packed {
        logic [2:0]            n;
        logic [MAX_DATA-1:0][7:0] data;
    } utf8_t;

    // hex digit decode: valid flag and value
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexd_t;

    // simple escape decode: valid flag and byte
    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } escd_t;

    function automatic hexd_t hex_digit(input logic [7:0] c);
        hexd_t r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic escd_t esc_map(input logic [7:0] c);
        escd_t r;
        r.ok = 1'b1;
        unique case (c)
            8'h22:   r.val = 8'h22;
            8'h5C:   r.val = 8'h5C;
            8'h2F:   r.val = 8'h2F;
            8'h62:   r.val = 8'h08;
            8'h66:   r.val = 8'h0C;
            8'h6E:   r.val = 8'h0A;
            8'h72:   r.val = 8'h0D;
            8'h74:   r.val = 8'h09;
            default:
            begin
                r.ok  = 1'b0;
                r.val = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic utf8_t encode_utf8(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp <= 21'h7F)
        begin
            r.n       = 3'd1;
            r.data[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF)
        begin
            r.n       = 3'd2;
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF)
        begin
            r.n       = 3'd3;
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.n       = 3'd4;
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

FILE: hdl/jsu_if.sv
// jsu_if: valid/ready channel interfaces for text bytes and result items
// depends on nothing

interface jsu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

FILE: hdl/jsu_front.sv
// jsu_front: parser state and per-byte classification into result jobs
// depends on jsu_pkg and jsu_if

module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    jsu_text_if.sink         text,
    input  logic             job_ready,
    output logic             job_push,
    output jsu_pkg::job_t    job
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    hex_reg, hex_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [9:0]     high_reg, high_next;
    logic           bad_reg, bad_next;

    logic           accept;
    logic           eot;
    logic [7:0]     c;
    logic           err_en;
    logic [3:0]     err_code;
    logic           done_en;
    jsu_pkg::hexd_t hd;
    jsu_pkg::escd_t ed;
    jsu_pkg::utf8_t enc;
    logic [15:0]    hv;
    logic           hbad;
    logic [20:0]    cp;

    assign text.ready = job_ready;
    assign accept     = text.valid && job_ready;
    assign c          = text.in_byte;
    assign eot        = text.end_of_text;

    // decode helpers
    assign hd   = jsu_pkg::hex_digit(c);
    assign ed   = jsu_pkg::esc_map(c);
    assign hbad = bad_reg | ~hd.ok;
    assign hv   = {hex_reg[11:0], (hd.ok ? hd.val : 4'd0)};
    assign cp   = (mode_reg == jsu_pkg::M_HEX2) ? (21'h10000 + {1'b0, high_reg, hv[9:0]})
                                                : {5'd0, hv};
    assign enc  = jsu_pkg::encode_utf8(cp);

    // next state and job contents
    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        cnt_next  = cnt_reg;
        high_next = high_reg;
        bad_next  = bad_reg;
        err_en    = 1'b0;
        err_code  = jsu_pkg::E_NONE;
        done_en   = 1'b0;
        job       = '0;

        unique case (mode_reg) inside
            jsu_pkg::M_STR:
            begin
                if (c == jsu_pkg::CH_QUOTE)
                begin
                    done_en   = 1'b1;
                    mode_next = jsu_pkg::M_IDLE;
                end
                else if (c == jsu_pkg::CH_BSLASH)
                begin
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_END_ESC;
                    end
                    else
                    begin
                        mode_next = jsu_pkg::M_ESC;
                    end
                end
                else
                begin
                    job.n_data  = 3'd1;
                    job.data[0] = c;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_UNTERM;
                    end
                end
            end

            jsu_pkg::M_ESC:
            begin
                if (ed.ok)
                begin
                    mode_next   = jsu_pkg::M_STR;
                    job.n_data  = 3'd1;
                    job.data[0] = ed.val;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_UNTERM;
                    end
                end
                else if (c == jsu_pkg::CH_U)
                begin
                    hex_next  = '0;
                    cnt_next  = '0;
                    bad_next  = 1'b0;
                    mode_next = jsu_pkg::M_HEX1;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_TRUNC_U;
                    end
                end
                else
                begin
                    err_en   = 1'b1;
                    err_code = jsu_pkg::E_BAD_ESC;
                end
            end

            jsu_pkg::M_HEX1, jsu_pkg::M_HEX2:
            begin
                hex_next = hv;
                bad_next = hbad;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    if (hbad)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_BAD_HEX;
                    end
                    else if (mode_reg == jsu_pkg::M_HEX1 && hv[15:10] == jsu_pkg::SUR_HIGH_TOP)
                    begin
                        high_next = hv[9:0];
                        if (eot)
                        begin
                            err_en   = 1'b1;
                            err_code = jsu_pkg::E_UNPAIRED;
                        end
                        else
                        begin
                            mode_next = jsu_pkg::M_WANTBS;
                        end
                    end
                    else if (mode_reg == jsu_pkg::M_HEX2 && hv[15:10] != jsu_pkg::SUR_LOW_TOP)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_BAD_LOW;
                    end
                    else
                    begin
                        mode_next  = jsu_pkg::M_STR;
                        job.n_data = enc.n;
                        job.data   = enc.data;
                        if (eot)
                        begin
                            err_en   = 1'b1;
                            err_code = jsu_pkg::E_UNTERM;
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_TRUNC_U;
                    end
                end
            end

            jsu_pkg::M_WANTBS:
            begin
                if (c == jsu_pkg::CH_BSLASH && !eot)
                begin
                    mode_next = jsu_pkg::M_WANTU;
                end
                else
                begin
                    err_en   = 1'b1;
                    err_code = jsu_pkg::E_UNPAIRED;
                end
            end

            jsu_pkg::M_WANTU:
            begin
                if (c == jsu_pkg::CH_U)
                begin
                    hex_next  = '0;
                    cnt_next  = '0;
                    bad_next  = 1'b0;
                    mode_next = jsu_pkg::M_HEX2;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_TRUNC_U;
                    end
                end
                else
                begin
                    err_en   = 1'b1;
                    err_code = jsu_pkg::E_UNPAIRED;
                end
            end

            jsu_pkg::M_DRAIN:
            begin
                if (eot)
                begin
                    mode_next = jsu_pkg::M_IDLE;
                end
            end

            // idle and unused codes wait for the opening quote
            default:
            begin
                if (c == jsu_pkg::CH_QUOTE)
                begin
                    mode_next = jsu_pkg::M_STR;
                    if (eot)
                    begin
                        err_en   = 1'b1;
                        err_code = jsu_pkg::E_UNTERM;
                    end
                end
                else
                begin
                    err_en   = 1'b1;
                    err_code = jsu_pkg::E_NO_QUOTE;
                end
            end
        endcase

        // trailing done or error result
        if (err_en)
        begin
            job.tail_en   = 1'b1;
            job.tail_kind = jsu_pkg::K_ERR;
            job.tail_code = err_code;
            mode_next     = eot ? jsu_pkg::M_IDLE : jsu_pkg::M_DRAIN;
        end
        else if (done_en)
        begin
            job.tail_en   = 1'b1;
            job.tail_kind = jsu_pkg::K_DONE;
            job.tail_code = jsu_pkg::E_NONE;
        end
    end

    // only bytes that cause results make a job
    assign job_push = accept && (job.n_data != 3'd0 || job.tail_en);

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jsu_pkg::M_IDLE;
            hex_reg  <= '0;
            cnt_reg  <= '0;
            high_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
            high_reg <= high_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

FILE: hdl/jsu_queue.sv
// jsu_queue: small fifo of result jobs between front and back
// depends on jsu_pkg

module jsu_queue
#(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output logic          head_valid,
    output jsu_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jsu_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign not_full   = (cnt_reg != FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hdl/jsu_back.sv
// jsu_back: unpacks queued jobs into single results behind an output register
// depends on jsu_pkg and jsu_if

module jsu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jsu_pkg::job_t head_job,
    output logic          pop,
    jsu_result_if.source  result
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic [3:0] code_reg;
    logic       last_reg;

    logic       load;
    logic       sel_final;
    logic [7:0] sel_byte;
    logic [1:0] sel_kind;
    logic [3:0] sel_code;

    assign result.valid      = valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.kind       = kind_reg;
    assign result.error_code = code_reg;
    assign result.last       = last_reg;

    assign load = head_valid && (!valid_reg || result.ready);
    assign pop  = load && sel_final;

    // pick the current result of the head job
    always_comb
    begin
        if (idx_reg < head_job.n_data)
        begin
            sel_byte  = head_job.data[idx_reg[1:0]];
            sel_kind  = jsu_pkg::K_DATA;
            sel_code  = jsu_pkg::E_NONE;
            sel_final = (idx_reg + 3'd1 == head_job.n_data) && !head_job.tail_en;
        end
        else
        begin
            sel_byte  = 8'h00;
            sel_kind  = head_job.tail_kind;
            sel_code  = head_job.tail_code;
            sel_final = 1'b1;
        end
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = sel_final ? 3'd0 : idx_reg + 3'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            kind_reg <= sel_kind;
            code_reg <= sel_code;
            last_reg <= sel_final;
        end
    end

endmodule

FILE: hdl/json_string_unescape_top.sv
// json_string_unescape_top: JSON string unescaper with utf-8 output
// depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back
//
//   channel   dir   payload                                    handshake
//   text      in    in_byte[8], end_of_text[1]                 valid/ready
//   result    out   out_byte[8], kind[2], error_code[4], last  valid/ready
//
// one text byte is taken per cycle while the job queue has room; a byte that
// causes results becomes one job of 1 to 5 results, and the back end sends one
// result per cycle while the result side is ready.
// a taken request is written to a queue slot, then loaded into the output register.
// reset clears the parser mode, the queue pointers and the output valid.
// a stalled result side fills the queue, then drops text ready.

module json_string_unescape_top
#(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    jsu_text_if.sink     text,
    jsu_result_if.source result
);

    jsu_pkg::job_t job;
    jsu_pkg::job_t head_job;
    logic          job_push;
    logic          q_not_full;
    logic          head_valid;
    logic          pop;

    // parse and classify
    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .job_ready (q_not_full),
        .job_push  (job_push),
        .job       (job)
    );

    // decoupling queue
    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .not_full   (q_not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // result serializer
    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_if and json_string_unescape_top from the hdl folder
// text requests go in through a queue-fed driver; results are checked in order

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SIDE_TEXT    = 0;
    localparam int SIDE_RESULT  = 1;

    // the eight simple escape letters, index 7 first
    localparam logic [7:0][7:0] ESC_LETTERS =
        {"t", "r", "n", "f", "b", "/", CH_BSLASH, CH_QUOTE};

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_req_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] code;
        logic       last;
    } unesc_result_t;

    logic clk;
    logic rst_n = 1'b0;

    // bench-side copies of the block inputs, known from time zero
    logic       send_valid = 1'b0;
    logic [7:0] send_byte  = 8'h00;
    logic       send_eot   = 1'b0;
    logic       take_ready = 1'b0;

    jsu_text_if   text();
    jsu_result_if result();

    assign text.valid       = send_valid;
    assign text.in_byte     = send_byte;
    assign text.end_of_text = send_eot;
    assign result.ready     = take_ready;

    json_string_unescape_top u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .result (result)
    );

    text_req_t     pending_text[$];
    unesc_result_t expected_results[$];
    unesc_result_t step_results[$];
    unesc_result_t seen_want;
    logic [7:0]    doc_bytes[$];

    int text_queued    = 0;
    int text_taken     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_wait;
    int recv_wait;
    int idle_style[2];
    int idle_left[2];

    // shadow state of the unescaper
    mode_t       ps_mode;
    logic [15:0] ps_hex;
    logic [1:0]  ps_digits;
    logic [9:0]  ps_high;
    logic        ps_bad;

    // clock and reset
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // shadow unescaper
    // ---------------------------------------------------------------

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // {known, byte} for the letter after a backslash
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            "/":       return {1'b1, 8'h2F};
            "b":       return {1'b1, 8'h08};
            "f":       return {1'b1, 8'h0C};
            "n":       return {1'b1, 8'h0A};
            "r":       return {1'b1, 8'h0D};
            "t":       return {1'b1, 8'h09};
            default:   return 9'h000;
        endcase
    endfunction

    function automatic void push_result(input logic [7:0] b, input kind_t k,
                                        input logic [3:0] code);
        unesc_result_t r;
        r.data = b;
        r.kind = k;
        r.code = code;
        r.last = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    // an error at end of text goes straight back to idle, else drop to end of text
    function automatic void raise_fault(input logic [3:0] code, input logic eot);
        push_result(8'h00, K_ERR, code);
        ps_mode = eot ? M_IDLE : M_DRAIN;
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
            push_result(cp[7:0], K_DATA, E_NONE);
        else if (cp < 21'h800)
        begin
            push_result({3'b110, cp[10:6]}, K_DATA, E_NONE);
            push_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
        else if (cp < 21'h10000)
        begin
            push_result({4'b1110, cp[15:12]}, K_DATA, E_NONE);
            push_result({2'b10, cp[11:6]}, K_DATA, E_NONE);
            push_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
        else
        begin
            push_result({5'b11110, cp[20:18]}, K_DATA, E_NONE);
            push_result({2'b10, cp[17:12]}, K_DATA, E_NONE);
            push_result({2'b10, cp[11:6]}, K_DATA, E_NONE);
            push_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
    endfunction

    function automatic void start_hex(input mode_t next_mode, input logic eot);
        ps_hex    = 16'h0000;
        ps_digits = 2'd0;
        ps_bad    = 1'b0;
        ps_mode   = next_mode;
        if (eot)
            raise_fault(E_TRUNC_U, 1'b1);
    endfunction

    // four digits are in: first value of an escape or the low half of a pair
    function automatic void finish_hex(input logic eot, input logic second);
        if (ps_bad)
            raise_fault(E_BAD_HEX, eot);
        else if (!second && ps_hex[15:10] == SUR_HIGH_TOP)
        begin
            ps_high = ps_hex[9:0];
            if (eot)
                raise_fault(E_UNPAIRED, 1'b1);
            else
                ps_mode = M_WANTBS;
        end
        else if (second && ps_hex[15:10] != SUR_LOW_TOP)
            raise_fault(E_BAD_LOW, eot);
        else
        begin
            ps_mode = M_STR;
            if (second)
                emit_code_point(21'h10000 + {1'b0, ps_high, ps_hex[9:0]});
            else
                emit_code_point({5'b0, ps_hex});
            if (eot)
                raise_fault(E_UNTERM, 1'b1);
        end
    endfunction

    // work out the results one accepted text request causes
    function automatic void predict_text_byte(input logic [7:0] c, input logic eot);
        logic [8:0] esc;
        int         nib;
        step_results.delete();
        case (ps_mode) inside
            M_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    push_result(8'h00, K_DONE, E_NONE);
                    ps_mode = M_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    if (eot)
                        raise_fault(E_END_ESC, 1'b1);
                    else
                        ps_mode = M_ESC;
                end
                else
                begin
                    push_result(c, K_DATA, E_NONE);
                    if (eot)
                        raise_fault(E_UNTERM, 1'b1);
                end
            end
            M_ESC:
            begin
                esc = simple_escape(c);
                if (esc[8])
                begin
                    ps_mode = M_STR;
                    push_result(esc[7:0], K_DATA, E_NONE);
                    if (eot)
                        raise_fault(E_UNTERM, 1'b1);
                end
                else if (c == CH_U)
                    start_hex(M_HEX1, eot);
                else
                    raise_fault(E_BAD_ESC, eot);
            end
            M_HEX1, M_HEX2:
            begin
                nib = nibble_of(c);
                if (nib < 0)
                begin
                    ps_bad = 1'b1;
                    nib    = 0;
                end
                ps_hex = {ps_hex[11:0], 4'(nib)};
                if (ps_digits == 2'd3)
                begin
                    ps_digits = 2'd0;
                    finish_hex(eot, ps_mode == M_HEX2);
                end
                else
                begin
                    ps_digits = ps_digits + 2'd1;
                    if (eot)
                        raise_fault(E_TRUNC_U, 1'b1);
                end
            end
            M_WANTBS:
            begin
                if (c == CH_BSLASH && !eot)
                    ps_mode = M_WANTU;
                else
                    raise_fault(E_UNPAIRED, eot);
            end
            M_WANTU:
            begin
                if (c == CH_U)
                    start_hex(M_HEX2, eot);
                else
                    raise_fault(E_UNPAIRED, eot);
            end
            M_DRAIN:
            begin
                if (eot)
                    ps_mode = M_IDLE;
            end
            default:
            begin
                if (c == CH_QUOTE)
                begin
                    ps_mode = M_STR;
                    if (eot)
                        raise_fault(E_UNTERM, 1'b1);
                end
                else
                    raise_fault(E_NO_QUOTE, eot);
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.insert(expected_results.size(), step_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // idle draws and reporting
    // ---------------------------------------------------------------

    // each side switches between no idling, light idling and full idling
    function automatic int draw_wait(input int side);
        if (idle_left[side] == 0)
        begin
            idle_style[side] = $urandom_range(0, 2);
            idle_left[side]  = $urandom_range(10, 60);
        end
        idle_left[side]--;
        case (idle_style[side])
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // driver: presents pending text requests
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_byte  <= 8'h00;
            send_eot   <= 1'b0;
            send_wait  = 0;
        end
        else
        begin
            if (send_valid && text.ready)
            begin
                predict_text_byte(send_byte, send_eot);
                text_taken++;
            end
            if (send_valid && !text.ready)
            begin
                // hold the request until it is taken
            end
            else if (send_wait > 0)
            begin
                send_valid <= 1'b0;
                send_wait--;
            end
            else if (pending_text.size() > 0)
            begin
                send_valid <= 1'b1;
                send_byte  <= pending_text[0].data;
                send_eot   <= pending_text[0].eot;
                void'(pending_text.pop_front());
                send_wait = draw_wait(SIDE_TEXT);
            end
            else
                send_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: takes results and checks them in order
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            recv_wait  = 0;
        end
        else
        begin
            if (result.valid && take_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf(
                        "unexpected result byte %02h kind %0d code %0d last %0d",
                        result.out_byte, result.kind, result.error_code, result.last));
                else
                begin
                    seen_want = expected_results.pop_front();
                    if (result.out_byte !== seen_want.data || result.kind !== seen_want.kind
                        || result.error_code !== seen_want.code
                        || result.last !== seen_want.last)
                        report_mismatch($sformatf(
                            "got byte %02h kind %0d code %0d last %0d, want %02h %0d %0d %0d",
                            result.out_byte, result.kind, result.error_code, result.last,
                            seen_want.data, seen_want.kind, seen_want.code, seen_want.last));
                end
                recv_wait = draw_wait(SIDE_RESULT);
            end
            if (recv_wait > 0)
            begin
                take_ready <= 1'b0;
                recv_wait--;
            end
            else
                take_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic add_text(input logic [7:0] b, input logic eot);
        text_req_t t;
        t.data = b;
        t.eot  = eot;
        pending_text.insert(pending_text.size(), t);
        text_queued++;
    endtask

    // wait until every request is taken and every result has come
    task automatic wait_quiet();
        while (text_taken != text_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // append one byte to the literal being built
    function automatic void add_doc(input logic [7:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (nibble_of(c) >= 0);
        return c;
    endfunction

    // value in a range, with the ends of the range favored
    function automatic logic [15:0] pick_range(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // backslash u and four digits; one digit made non-hex when bad_pos is 0..3
    task automatic push_u(input logic [15:0] v, input int bad_pos);
        add_doc(CH_BSLASH);
        add_doc(CH_U);
        for (int i = 0; i < 4; i++)
        begin
            if (i == bad_pos)
                add_doc(non_hex_byte());
            else
                add_doc(hex_char(v[15 - 4 * i -: 4]));
        end
    endtask

    task automatic add_segment();
        int         sel;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            // plain or raw byte
            do
                c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126))
                                                : 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_BSLASH);
            add_doc(c);
        end
        else if (sel < 50)
        begin
            add_doc(CH_BSLASH);
            add_doc(ESC_LETTERS[$urandom_range(0, 7)]);
        end
        else if (sel < 85)
        begin
            case ($urandom_range(0, 4))
                0: push_u(pick_range(16'h0000, 16'h007F), -1);
                1: push_u(pick_range(16'h0080, 16'h07FF), -1);
                2:
                begin
                    if ($urandom_range(0, 1))
                        push_u(pick_range(16'h0800, 16'hD7FF), -1);
                    else
                        push_u(pick_range(16'hE000, 16'hFFFF), -1);
                end
                // lone low surrogate
                3: push_u(pick_range(16'hDC00, 16'hDFFF), -1);
                default:
                begin
                    push_u(pick_range(16'hD800, 16'hDBFF), -1);
                    push_u(pick_range(16'hDC00, 16'hDFFF), -1);
                end
            endcase
        end
        else if (sel < 90)
        begin
            // unknown escape letter
            do
                c = 8'($urandom_range(0, 255));
            while (simple_escape(c) != 9'h000 || c == CH_U);
            add_doc(CH_BSLASH);
            add_doc(c);
        end
        else if (sel < 94)
        begin
            // bad hex digit, alone or in the low half of a pair
            if ($urandom_range(0, 1))
                push_u(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
            else
            begin
                push_u(pick_range(16'hD800, 16'hDBFF), -1);
                push_u(pick_range(16'hDC00, 16'hDFFF), $urandom_range(0, 3));
            end
        end
        else if (sel < 97)
        begin
            // high surrogate not followed by backslash u
            push_u(pick_range(16'hD800, 16'hDBFF), -1);
            if ($urandom_range(0, 1))
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_BSLASH);
                add_doc(c);
            end
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_U);
                add_doc(CH_BSLASH);
                add_doc(c);
            end
        end
        else
        begin
            // high surrogate followed by a value outside the low range
            push_u(pick_range(16'hD800, 16'hDBFF), -1);
            if ($urandom_range(0, 1))
                push_u(pick_range(16'h0000, 16'hDBFF), -1);
            else
                push_u(pick_range(16'hE000, 16'hFFFF), -1);
        end
    endtask

    // one string literal, sometimes with junk ahead, cut short or left open
    task automatic add_literal();
        int         keep;
        logic       eot_last;
        logic [7:0] c;
        doc_bytes.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE);
            add_doc(c);
        end
        add_doc(CH_QUOTE);
        repeat ($urandom_range(0, 6))
            add_segment();
        if ($urandom_range(0, 3) != 0)
            add_doc(CH_QUOTE);
        keep = doc_bytes.size();
        if ($urandom_range(0, 4) == 0)
            keep = $urandom_range(1, doc_bytes.size());
        eot_last = ($urandom_range(0, 6) != 0);
        for (int i = 0; i < keep; i++)
            add_text(doc_bytes[i], (i == keep - 1) ? eot_last : 1'b0);
    endtask

    initial
    begin
        int target;
        ps_mode       = M_IDLE;
        ps_hex        = 16'h0000;
        ps_digits     = 2'd0;
        ps_high       = 10'h000;
        ps_bad        = 1'b0;
        idle_style    = '{0, 0};
        idle_left     = '{0, 0};

        // junk before the quote, then dropped up to end of text
        add_text("x", 1'b0);
        add_text(8'h00, 1'b1);
        // raw high byte, simple escape, surrogate pair, closing quote
        add_text(CH_QUOTE, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(CH_BSLASH, 1'b0);
        add_text("t", 1'b0);
        add_text(CH_BSLASH, 1'b0);
        add_text(CH_U, 1'b0);
        add_text("d", 1'b0);
        add_text("8", 1'b0);
        add_text("3", 1'b0);
        add_text("d", 1'b0);
        add_text(CH_BSLASH, 1'b0);
        add_text(CH_U, 1'b0);
        add_text("D", 1'b0);
        add_text("E", 1'b0);
        add_text("0", 1'b0);
        add_text("0", 1'b0);
        add_text(CH_QUOTE, 1'b0);
        // text ends after a backslash
        add_text(CH_QUOTE, 1'b0);
        add_text(CH_BSLASH, 1'b1);
        // unknown escape letter on the last byte
        add_text(CH_QUOTE, 1'b0);
        add_text(CH_BSLASH, 1'b0);
        add_text("q", 1'b1);

        // sender holds off until the block has gone quiet
        wait_quiet();

        target = text_queued + RANDOM_ITEMS / 2;
        while (text_queued < target)
            add_literal();
        wait_quiet();
        target = text_queued + RANDOM_ITEMS / 2;
        while (text_queued < target)
            add_literal();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/jsu_pkg.sv
hdl/jsu_if.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_top.sv
verif/tb_top.sv
